### hw/rtl/stta_pkg.sv
// Shared types and constants for the sleeper table time advance block.
`timescale 1ns / 1ps
package stta_pkg;

  // Item modes
  localparam logic [2:0] MODE_ATTACH  = 3'd0;
  localparam logic [2:0] MODE_DETACH  = 3'd1;
  localparam logic [2:0] MODE_SLEEP   = 3'd2;
  localparam logic [2:0] MODE_ADVANCE = 3'd3;
  localparam logic [2:0] MODE_HARVEST = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_AWAKE     = 2'd3;

  // Field widths
  localparam int TAG_IN_W  = 16;
  localparam int SLOT_W    = 4;
  localparam int MASK_W    = 16;
  localparam int TIME_W    = 32;
  localparam int POWER_W   = 24;
  localparam int PROD_W    = 56;

  localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] CAP_RESET    = 32'd10_000_000;
  localparam logic [31:0] BATT_RESET   = 32'd5_000_000;

  // Divide by 100, one byte of the dividend per step: q = (v * 5243) >> 19
  // is exact for v < 25600.
  localparam int unsigned DIV_BASE    = 100;
  localparam int unsigned RECIP_100   = 5243;
  localparam int          RECIP_SHIFT = 19;
  localparam int          DIV_STEPS   = 7;

  // Shared arithmetic unit
  typedef logic [1:0] arith_op_t;
  localparam arith_op_t ARITH_ADD    = 2'd0;
  localparam arith_op_t ARITH_MAC_LO = 2'd1;
  localparam arith_op_t ARITH_MAC_HI = 2'd2;
  localparam arith_op_t ARITH_DIGIT  = 2'd3;

  typedef struct packed {
    arith_op_t           op;
    logic [PROD_W-1:0]   a;
    logic [31:0]         b;
    logic [POWER_W-1:0]  c;
  } arith_req_t;

  // Slot store commands
  typedef logic [2:0] slot_op_t;
  localparam slot_op_t SLOT_NONE   = 3'd0;
  localparam slot_op_t SLOT_ATTACH = 3'd1;
  localparam slot_op_t SLOT_DETACH = 3'd2;
  localparam slot_op_t SLOT_SLEEP  = 3'd3;
  localparam slot_op_t SLOT_WAKE   = 3'd4;

  typedef struct packed {
    slot_op_t          op;
    logic [TIME_W-1:0] wake;
  } slot_cmd_t;

endpackage

### hw/rtl/stta_arith.sv
// Shared arithmetic unit: add, multiply-accumulate halves, divide-by-100 digit step.
`timescale 1ns / 1ps
module stta_arith import stta_pkg::*; (
  input  arith_req_t          req,
  output logic [PROD_W-1:0]   y
);

  logic [15:0] mul_in;
  logic [39:0] prod;
  logic [14:0] dig_v;
  logic [27:0] dig_p;
  logic [7:0]  dig_q;
  logic [14:0] dig_r;

  always_comb begin
    mul_in = (req.op == ARITH_MAC_HI) ? req.b[31:16] : req.b[15:0];
    prod   = 40'(req.c) * 40'(mul_in);
    // remainder so far (below 100) followed by the next dividend byte
    dig_v  = {req.a[6:0], req.b[7:0]};
    dig_p  = 28'(dig_v) * 28'(RECIP_100);
    dig_q  = dig_p[RECIP_SHIFT +: 8];
    dig_r  = dig_v - 15'(dig_q) * 15'(DIV_BASE);
    unique case (req.op)
      ARITH_ADD:    y = PROD_W'({1'b0, req.a[31:0]} + {1'b0, req.b});
      ARITH_MAC_LO: y = req.a + PROD_W'(prod);
      ARITH_MAC_HI: y = req.a + {prod, 16'b0};
      ARITH_DIGIT:  y = {{(PROD_W-15){1'b0}}, dig_r[6:0], dig_q};
    endcase
  end

endmodule

### hw/rtl/stta_slots.sv
// Slot table: valid and asleep flags in flops, tags and wake times in memories.
`timescale 1ns / 1ps
module stta_slots import stta_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int TW    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [TW-1:0]            rd_tag,
  output logic [TIME_W-1:0]        rd_wake,
  input  slot_cmd_t                cmd,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [TW-1:0]            wr_tag,
  output logic [SLOTS-1:0]         valid,
  output logic [SLOTS-1:0]         asleep
);

  logic [TW-1:0]     tag_mem  [SLOTS];
  logic [TIME_W-1:0] wake_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      asleep <= '0;
    end else begin
      unique case (cmd.op)
        SLOT_NONE: ;
        SLOT_ATTACH: begin
          valid[wr_addr]  <= 1'b1;
          asleep[wr_addr] <= 1'b0;
        end
        SLOT_DETACH: valid[wr_addr]  <= 1'b0;
        SLOT_SLEEP:  asleep[wr_addr] <= 1'b1;
        SLOT_WAKE:   asleep[wr_addr] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == SLOT_ATTACH) begin
      tag_mem[wr_addr]  <= wr_tag;
      wake_mem[wr_addr] <= '0;
    end else if (cmd.op == SLOT_SLEEP) begin
      wake_mem[wr_addr] <= cmd.wake;
    end
    if (rd_en) begin
      rd_tag  <= tag_mem[rd_addr];
      rd_wake <= wake_mem[rd_addr];
    end
  end

endmodule

### hw/rtl/sleeper_table_time_advance.sv
// Top level: task slot table with event clock and battery, run by a small sequencer.
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_stall   mode task_tag delay_hundredths harvest_uj
//                                             power_draw_uw
//   out      out        out_valid / out_stall status slot_index woken_mask time_now
//                                             battery_level
//   cfg      in         cfg_valid / cfg_ready cfg_data (battery capacity)
//
// One item at a time; scans read one slot per cycle. Between accept and result beat,
// attach, detach and sleep scan the table; advance runs two scans, two multiply halves
// and seven divide-by-100 digit steps, or stops after the first scan if a slot is awake;
// harvest is one add; modes 5..7 go straight to the result; then the block returns to idle.
// Synchronous reset clears all slots, the clock and restores battery and capacity.
// A result held by out_stall keeps the next item from finishing, not from entering.
`timescale 1ns / 1ps
module sleeper_table_time_advance import stta_pkg::*; #(
  parameter int SLOTS    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          mode,
  input  logic [TAG_IN_W-1:0] task_tag,
  input  logic [31:0]         delay_hundredths,
  input  logic [31:0]         harvest_uj,
  input  logic [POWER_W-1:0]  power_draw_uw,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [MASK_W-1:0]   woken_mask,
  output logic [TIME_W-1:0]   time_now,
  output logic [31:0]         battery_level,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ATT      = 4'd1;
  localparam logic [3:0] S_DET      = 4'd2;
  localparam logic [3:0] S_SLP      = 4'd3;
  localparam logic [3:0] S_ADV_SCAN = 4'd4;
  localparam logic [3:0] S_ADV_WAKE = 4'd5;
  localparam logic [3:0] S_MUL_LO   = 4'd6;
  localparam logic [3:0] S_MUL_HI   = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_CHARGE   = 4'd9;
  localparam logic [3:0] S_HARV     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]          state;
  logic [CW-1:0]       idx;
  logic                dv;
  logic [AW-1:0]       didx;
  logic [TW-1:0]       tag_r;
  logic [31:0]         delay_r;
  logic [31:0]         gain_r;
  logic [POWER_W-1:0]  power_r;
  logic [1:0]          status_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOTS-1:0]    woken_r;
  logic [TIME_W-1:0]   target;
  logic                awake;
  logic [TIME_W-1:0]   delta;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   quot;
  logic [6:0]          rem;
  logic [2:0]          dcnt;
  logic [TIME_W-1:0]   clock_now;
  logic [31:0]         battery;
  logic [31:0]         capacity;

  logic                scan;
  logic                issue;
  logic                proc;
  logic                last;
  logic                tag_hit;
  logic [AW-1:0]       ia;
  logic [TW-1:0]       rd_tag;
  logic [TIME_W-1:0]   rd_wake;
  logic [SLOTS-1:0]    valid;
  logic [SLOTS-1:0]    asleep;
  slot_cmd_t           cmd;
  logic [AW-1:0]       wr_addr;
  arith_req_t          req;
  logic [PROD_W-1:0]   y;

  stta_slots #(.SLOTS(SLOTS), .TW(TW)) u_slots (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (ia),
    .rd_tag  (rd_tag),
    .rd_wake (rd_wake),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_tag  (tag_r),
    .valid   (valid),
    .asleep  (asleep)
  );

  stta_arith u_arith (
    .req (req),
    .y   (y)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    ia      = idx[AW-1:0];
    scan    = (state == S_DET) || (state == S_SLP) ||
              (state == S_ADV_SCAN) || (state == S_ADV_WAKE);
    issue   = scan && (idx < CW'(SLOTS));
    proc    = scan && dv;
    last    = proc && (didx == LAST_SLOT);
    tag_hit = valid[didx] && (rd_tag == tag_r);
  end

  // slot store commands
  always_comb begin
    cmd.op   = SLOT_NONE;
    cmd.wake = y[TIME_W-1:0];
    wr_addr  = didx;
    unique case (state)
      S_ATT: begin
        wr_addr = ia;
        if (!valid[ia]) cmd.op = SLOT_ATTACH;
      end
      S_DET:      if (proc && tag_hit) cmd.op = SLOT_DETACH;
      S_SLP:      if (proc && tag_hit) cmd.op = SLOT_SLEEP;
      S_ADV_WAKE: if (proc && valid[didx] && rd_wake == target) cmd.op = SLOT_WAKE;
      default: ;
    endcase
  end

  // shared arithmetic unit operands
  always_comb begin
    req.op = ARITH_ADD;
    req.a  = PROD_W'(clock_now);
    req.b  = delay_r;
    req.c  = power_r;
    unique case (state)
      S_HARV: begin
        req.a = PROD_W'(battery);
        req.b = gain_r;
      end
      S_MUL_LO: begin
        req.op = ARITH_MAC_LO;
        req.a  = '0;
        req.b  = delta;
      end
      S_MUL_HI: begin
        req.op = ARITH_MAC_HI;
        req.a  = acc;
        req.b  = delta;
      end
      S_DIV: begin
        req.op = ARITH_DIGIT;
        req.a  = PROD_W'(rem);
        req.b  = 32'(acc[PROD_W-1 -: 8]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dv        <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      clock_now <= '0;
      battery   <= BATT_RESET;
      capacity  <= CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) capacity <= cfg_data;

      if (scan) begin
        if (issue) begin
          idx  <= idx + 1'b1;
          didx <= ia;
        end
        dv <= issue;
      end

      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tag_r    <= task_tag[TW-1:0];
            delay_r  <= delay_hundredths;
            gain_r   <= harvest_uj;
            power_r  <= power_draw_uw;
            status_r <= ST_OK;
            slot_r   <= '0;
            woken_r  <= '0;
            target   <= TIME_MAX;
            awake    <= 1'b0;
            idx      <= '0;
            dv       <= 1'b0;
            unique case (mode)
              MODE_ATTACH:  state <= S_ATT;
              MODE_DETACH:  state <= S_DET;
              MODE_SLEEP:   state <= S_SLP;
              MODE_ADVANCE: state <= S_ADV_SCAN;
              MODE_HARVEST: state <= S_HARV;
              default:      state <= S_DONE;
            endcase
          end
        end
        S_ATT: begin
          if (!valid[ia]) begin
            slot_r <= SLOT_W'(ia);
            state  <= S_DONE;
          end else if (ia == LAST_SLOT) begin
            status_r <= ST_FULL;
            state    <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DET: begin
          if (last) state <= S_DONE;
        end
        S_SLP: begin
          if (proc && tag_hit) begin
            slot_r <= SLOT_W'(didx);
            state  <= S_DONE;
          end else if (last) begin
            status_r <= ST_NOT_FOUND;
            state    <= S_DONE;
          end
        end
        S_ADV_SCAN: begin
          if (proc) begin
            if (valid[didx] && !asleep[didx]) awake <= 1'b1;
            if (valid[didx] && rd_wake >= clock_now && rd_wake < target) target <= rd_wake;
          end
          // dv already drops here, the scan has issued its last read
          if (last) begin
            idx <= '0;
            if (awake || (valid[didx] && !asleep[didx])) begin
              status_r <= ST_AWAKE;
              state    <= S_DONE;
            end else begin
              state <= S_ADV_WAKE;
            end
          end
        end
        S_ADV_WAKE: begin
          if (proc && valid[didx] && rd_wake == target) woken_r[didx] <= 1'b1;
          if (last) begin
            delta <= target - clock_now;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          acc   <= y;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= y;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // long division by 100, most significant byte first
          acc  <= acc << 8;
          quot <= {quot[PROD_W-9:0], y[7:0]};
          rem  <= y[14:8];
          if (dcnt == 3'(DIV_STEPS - 1)) state <= S_CHARGE;
          else dcnt <= dcnt + 1'b1;
        end
        S_CHARGE: begin
          if (quot[PROD_W-1:32] == '0 && quot[31:0] <= battery) battery <= battery - quot[31:0];
          else battery <= '0;
          clock_now <= (target == TIME_MAX) ? '0 : target;
          state     <= S_DONE;
        end
        S_HARV: begin
          if (y[32:0] > {1'b0, capacity}) battery <= capacity;
          else battery <= y[31:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status        <= status_r;
      slot_index    <= slot_r;
      woken_mask    <= MASK_W'(woken_r);
      time_now      <= clock_now;
      battery_level <= battery;
    end
  end

endmodule

### tb/sv/sleeper_table_time_advance_test.sv
// Self-checking testbench for the sleeper table time advance block.
`timescale 1ns / 1ps
module sleeper_table_time_advance_test;
  import stta_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int HUNDRED      = 100;
  localparam int IDLE_PCT     = 18;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 6;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int TAIL_CYCLES  = 60;
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] tag;
    logic [31:0] delay;
    logic [31:0] gain;
    logic [23:0] power;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] woken;
    logic [31:0] now;
    logic [31:0] batt;
  } result_t;

  typedef struct packed {
    item_t   stim;
    logic    chk;
    result_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [15:0] task_tag;
  logic [31:0] delay_hundredths;
  logic [31:0] harvest_uj;
  logic [23:0] power_draw_uw;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  slot_index;
  logic [15:0] woken_mask;
  logic [31:0] time_now;
  logic [31:0] battery_level;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // predicted block state
  logic        slot_live   [NUM_SLOTS];
  logic [15:0] slot_owner  [NUM_SLOTS];
  logic        slot_dozing [NUM_SLOTS];
  logic [31:0] slot_alarm  [NUM_SLOTS];
  logic [31:0] now_ticks;
  logic [31:0] store_uj;
  logic [31:0] cap_uj;

  result_t results_due [$];
  row_t    dir_rows [$];
  int      errors = 0;
  int      idle_pct = IDLE_PCT;
  int      cycle_count;

  sleeper_table_time_advance #(
    .SLOTS    (NUM_SLOTS),
    .TAG_BITS (16)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .task_tag         (task_tag),
    .delay_hundredths (delay_hundredths),
    .harvest_uj       (harvest_uj),
    .power_draw_uw    (power_draw_uw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .slot_index       (slot_index),
    .woken_mask       (woken_mask),
    .time_now         (time_now),
    .battery_level    (battery_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Applies one item to the predicted table and returns the result it yields.
  function automatic result_t table_step(input item_t it);
    result_t     r;
    logic        found;
    logic        awake;
    logic [31:0] target;
    logic [31:0] delta;
    logic [55:0] drain;
    logic [32:0] sum;
    r = '0;
    found = 1'b0;
    awake = 1'b0;
    case (it.mode)
      MODE_ATTACH: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!found && !slot_live[k]) begin
            found = 1'b1;
            slot_live[k] = 1'b1;
            slot_owner[k] = it.tag;
            slot_dozing[k] = 1'b0;
            slot_alarm[k] = '0;
            r.slot = k[3:0];
          end
        end
        if (!found) r.status = ST_FULL;
      end
      MODE_DETACH: begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (slot_live[k] && slot_owner[k] == it.tag) slot_live[k] = 1'b0;
      end
      MODE_SLEEP: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!found && slot_live[k] && slot_owner[k] == it.tag) begin
            found = 1'b1;
            slot_alarm[k] = now_ticks + it.delay;
            slot_dozing[k] = 1'b1;
            r.slot = k[3:0];
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      MODE_ADVANCE: begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (slot_live[k] && !slot_dozing[k]) awake = 1'b1;
        if (awake) begin
          r.status = ST_AWAKE;
        end else begin
          // earliest alarm not behind the clock; none found means all ones
          target = TIME_MAX;
          for (int k = 0; k < NUM_SLOTS; k++)
            if (slot_live[k] && slot_alarm[k] < target && slot_alarm[k] >= now_ticks)
              target = slot_alarm[k];
          for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_live[k] && slot_alarm[k] == target) begin
              slot_dozing[k] = 1'b0;
              r.woken[k] = 1'b1;
            end
          end
          delta = target - now_ticks;
          drain = ({32'b0, it.power} * {24'b0, delta}) / HUNDRED;
          if (drain <= {24'b0, store_uj}) store_uj = store_uj - drain[31:0];
          else store_uj = '0;
          now_ticks = (target == TIME_MAX) ? '0 : target;
        end
      end
      MODE_HARVEST: begin
        sum = {1'b0, store_uj} + {1'b0, it.gain};
        if (sum > {1'b0, cap_uj}) sum = {1'b0, cap_uj};
        store_uj = sum[31:0];
      end
      default: ;
    endcase
    r.now = now_ticks;
    r.batt = store_uj;
    return r;
  endfunction

  // Mostly well-formed traffic: put awake slots to sleep, advance once all doze.
  function automatic item_t next_random_item();
    item_t       it;
    logic [15:0] live_tags  [$];
    logic [15:0] awake_tags [$];
    int          pick;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (slot_live[k]) begin
        live_tags.push_back(slot_owner[k]);
        if (!slot_dozing[k]) awake_tags.push_back(slot_owner[k]);
      end
    end
    it.tag = 16'($urandom);
    case ($urandom_range(9))
      0: it.delay = '0;
      1: it.delay = $urandom;
      2: it.delay = TIME_MAX - now_ticks;
      3: it.delay = TIME_MAX;
      default: it.delay = $urandom_range(2000);
    endcase
    case ($urandom_range(7))
      0: it.gain = '0;
      1: it.gain = TIME_MAX;
      2: it.gain = $urandom;
      default: it.gain = $urandom_range(200_000);
    endcase
    case ($urandom_range(7))
      0: it.power = '0;
      1: it.power = 24'hFF_FFFF;
      2: it.power = 24'($urandom);
      default: it.power = 24'($urandom_range(5000));
    endcase
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.mode = 3'($urandom_range(7));
    end else if (pick < 55) begin
      if (awake_tags.size() != 0) begin
        it.mode = MODE_SLEEP;
        it.tag = awake_tags[$urandom_range(awake_tags.size() - 1)];
      end else begin
        it.mode = MODE_ADVANCE;
      end
    end else if (pick < 72) begin
      it.mode = MODE_ATTACH;
      if (live_tags.size() != 0 && $urandom_range(7) == 0)
        it.tag = live_tags[$urandom_range(live_tags.size() - 1)];
    end else if (pick < 82) begin
      it.mode = MODE_DETACH;
      if (live_tags.size() != 0 && $urandom_range(3) != 0)
        it.tag = live_tags[$urandom_range(live_tags.size() - 1)];
    end else if (pick < 92) begin
      it.mode = MODE_HARVEST;
    end else begin
      it.mode = $urandom_range(1) ? MODE_SLEEP : MODE_ADVANCE;
    end
    return it;
  endfunction

  function automatic void add_row(input logic [2:0] m, input logic [15:0] tg,
                                  input logic [31:0] dl, input logic [31:0] gn,
                                  input logic [23:0] pw, input logic chk,
                                  input logic [1:0] st, input logic [3:0] sl,
                                  input logic [15:0] wk, input logic [31:0] nw,
                                  input logic [31:0] bt);
    row_t row;
    row.stim = '{mode: m, tag: tg, delay: dl, gain: gn, power: pw};
    row.chk = chk;
    row.want = '{status: st, slot: sl, woken: wk, now: nw, batt: bt};
    dir_rows.push_back(row);
  endfunction

  // Drives one beat, holds it through stall, records the predicted result.
  task automatic send_item(input item_t it, input logic chk, input result_t want);
    result_t got;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    mode             <= it.mode;
    task_tag         <= it.tag;
    delay_hundredths <= it.delay;
    harvest_uj       <= it.gain;
    power_draw_uw    <= it.power;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = table_step(it);
    results_due.push_back(chk ? want : got);
  endtask

  // Capacity writes only happen with the block drained.
  task automatic write_capacity(input logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_uj = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk)
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    result_t exp_r;
    result_t act_r;
    if (!rst && out_valid && !out_stall) begin
      act_r = '{status: status, slot: slot_index, woken: woken_mask,
                now: time_now, batt: battery_level};
      if (results_due.size() == 0) begin
        if (errors < 10)
          $display("unexpected beat: status %0d slot %0d woken %h time %0d batt %0d",
                   act_r.status, act_r.slot, act_r.woken, act_r.now, act_r.batt);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        if (act_r.status !== exp_r.status || act_r.slot !== exp_r.slot ||
            act_r.woken !== exp_r.woken || act_r.now !== exp_r.now ||
            act_r.batt !== exp_r.batt) begin
          if (errors < 10) begin
            $display("mismatch: exp st %0d slot %0d woken %h time %0d batt %0d",
                     exp_r.status, exp_r.slot, exp_r.woken, exp_r.now, exp_r.batt);
            $display("          got st %0d slot %0d woken %h time %0d batt %0d",
                     act_r.status, act_r.slot, act_r.woken, act_r.now, act_r.batt);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    item_t       it;
    int          done;
    logic [31:0] caps [NUM_PHASES];
    rst              = 1'b1;
    in_valid         = 1'b0;
    mode             = MODE_ATTACH;
    task_tag         = '0;
    delay_hundredths = '0;
    harvest_uj       = '0;
    power_draw_uw    = '0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot_live[k]   = 1'b0;
      slot_owner[k]  = '0;
      slot_dozing[k] = 1'b0;
      slot_alarm[k]  = '0;
    end
    now_ticks = '0;
    store_uj  = BATT_RESET;
    cap_uj    = CAP_RESET;

    // empty table advance: no alarm, clock wraps back to zero
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'd0, 1, ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_SPARE5, 16'h1234, 32'd5, 32'd5, 24'd5, 1, ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_SPARE7, 16'hFFFF, TIME_MAX, TIME_MAX, 24'hFF_FFFF, 1,
            ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_SLEEP, 16'hFFFF, 32'd10, 32'd0, 24'd0, 1,
            ST_NOT_FOUND, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_DETACH, 16'h1234, 32'd0, 32'd0, 24'd0, 1, ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_ATTACH, 16'h0000, 32'd0, 32'd0, 24'd0, 1, ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_ATTACH, 16'hFFFF, 32'd0, 32'd0, 24'd0, 1, ST_OK, 1, 16'h0, 0, BATT_RESET);
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'hFF_FFFF, 1,
            ST_AWAKE, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_SLEEP, 16'h0000, TIME_MAX, 32'd0, 24'd0, 1, ST_OK, 0, 16'h0, 0, BATT_RESET);
    add_row(MODE_SLEEP, 16'hFFFF, 32'd100, 32'd0, 24'd0, 1, ST_OK, 1, 16'h0, 0, BATT_RESET);
    // full power for one second drains the battery to zero
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'hFF_FFFF, 1, ST_OK, 0, 16'h0002, 100, 0);
    add_row(MODE_HARVEST, 16'h0000, 32'd0, TIME_MAX, 24'd0, 1, ST_OK, 0, 16'h0, 100, CAP_RESET);
    add_row(MODE_SLEEP, 16'hFFFF, 32'd0, 32'd0, 24'd0, 1, ST_OK, 1, 16'h0, 100, CAP_RESET);
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'd1, 0, ST_OK, 0, 16'h0, 0, 0);
    // wake time wraps behind the clock
    add_row(MODE_SLEEP, 16'hFFFF, TIME_MAX, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'd3000, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'd3000, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_ATTACH, 16'h00FF, 32'd0, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_ATTACH, 16'h00FF, 32'd0, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_DETACH, 16'h00FF, 32'd0, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_DETACH, 16'h0000, 32'd0, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_HARVEST, 16'h0000, 32'd0, 32'd0, 24'd0, 0, ST_OK, 0, 16'h0, 0, 0);
    add_row(MODE_ADVANCE, 16'h0000, 32'd0, 32'd0, 24'd777, 0, ST_OK, 0, 16'h0, 0, 0);

    caps[0] = TIME_MAX;
    caps[1] = 32'd0;
    caps[2] = 32'd2_500_000;
    caps[3] = $urandom;
    caps[4] = CAP_RESET;
    caps[5] = TIME_MAX;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].chk, dir_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(caps[ph]);
      idle_pct = (ph == 3) ? 0 : IDLE_PCT;
      // odd phases open by overfilling the table
      if (ph % 2 == 1) begin
        repeat (NUM_SLOTS + 2) begin
          it = next_random_item();
          it.mode = MODE_ATTACH;
          it.tag = 16'($urandom);
          send_item(it, 1'b0, '0);
        end
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        it = next_random_item();
        send_item(it, 1'b0, '0);
        if (it.mode <= MODE_HARVEST) done++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && results_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
